// ===== rtl/core/esf_pkg.sv =====
`default_nettype none
package esf_pkg;

   localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
   localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;
   localparam logic [63:0] RNG_SEED  = 64'h9E3779B97F4A7C15;
   localparam logic [15:0] ADAPT_PERIOD = 16'd1000;
   localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;

   localparam logic [2:0] MODE_OFF   = 3'd0;
   localparam logic [2:0] MODE_RAND  = 3'd1;
   localparam logic [2:0] MODE_LIMIT = 3'd2;
   localparam logic [2:0] MODE_ADAPT = 3'd3;
   localparam logic [2:0] MODE_HASH  = 3'd4;

   localparam logic [2:0] REG_MODE   = 3'd0;
   localparam logic [2:0] REG_BASE   = 3'd1;
   localparam logic [2:0] REG_BYPASS = 3'd2;
   localparam logic [2:0] REG_LIMIT  = 3'd3;
   localparam logic [2:0] REG_WINDOW = 3'd4;
   localparam logic [2:0] REG_THRESH = 3'd5;
   localparam logic [2:0] REG_MINRT  = 3'd6;
   localparam logic [2:0] REG_SEED   = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALLOW,
      ST_DIV,
      ST_DECIDE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic take_byte;
      logic take_tick;
      logic allow_start;
      logic div_start;
      logic div_step;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic is_last;
      logic need_div;
      logic div_done;
      logic allow_done;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/esf_ctrl.sv =====
`default_nettype none
module esf_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_kind,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire logic [2:0]      mode,
   input  wire esf_pkg::sts_type sts,
   output esf_pkg::cmd_type     cmd
);
   import esf_pkg::*;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind && sts.is_last) begin
               if (mode == MODE_LIMIT) state_in = ST_ALLOW;
               else if (mode == MODE_ADAPT && sts.need_div) state_in = ST_DIV;
               else state_in = ST_DECIDE;
            end
         end
         ST_ALLOW: if (sts.allow_done) state_in = ST_DECIDE;
         ST_DIV:   if (sts.div_done) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      cmd = '0;
      cmd.take_byte = accept && req_kind;
      cmd.take_tick = accept && !req_kind;
      cmd.allow_start = (state_ff == ST_IDLE) && accept && req_kind && sts.is_last;
      cmd.div_start = cmd.allow_start && (mode == MODE_ADAPT) && sts.need_div;
      cmd.div_step = (state_ff == ST_DIV);
      cmd.decide = (state_ff == ST_DECIDE);
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

// ===== rtl/core/esf_dp.sv =====
`default_nettype none
module esf_dp #(
   parameter int RATE_BITS = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire esf_pkg::cmd_type cmd,
   output esf_pkg::sts_type      sts,
   input  wire logic [2:0]       req_level,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_last_byte,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [63:0]      csr_data,
   output logic [2:0]            mode,
   output logic                  rsp_keep,
   output logic                  rsp_bypassed,
   output logic                  rsp_throttling,
   output logic [16:0]           rsp_current_rate,
   output logic [31:0]           rsp_total_seen,
   output logic [31:0]           rsp_kept_seen,
   output logic [31:0]           rsp_dropped_seen,
   output logic [31:0]           rsp_bypass_seen
);
   import esf_pkg::*;

   localparam int QW = (COUNT_WIDTH >= 49) ? COUNT_WIDTH + 1 : 50;
   localparam int LW = (COUNT_WIDTH + 11 > 36) ? COUNT_WIDTH + 11 : 36;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [QW-1:0] RATE_FULL = QW'(1) << RATE_BITS;

   logic [2:0]  mode_ff;
   logic [16:0] base_ff, minrt_ff;
   logic [7:0]  bypass_ff;
   logic [19:0] lps_ff;
   logic [15:0] win_ff;
   logic [31:0] thr_ff;
   logic [63:0] seed_ff;

   logic [63:0] rng_ff, hash_ff, hfin_ff, hash_in, hmix;
   logic [15:0] lel_ff, ael_ff;
   logic [COUNT_WIDTH-1:0] lcnt_ff, acnt_ff, nval_ff;
   logic [16:0] eff_ff;
   logic        thr_flag_ff;
   logic [COUNT_WIDTH-1:0] st0_ff, st1_ff, st2_ff, st3_ff;
   logic [2:0]  lvl_ff;
   logic [35:0] prod_ff;
   logic        prod_vld_ff;
   logic [QW-1:0] rem_ff, quo_ff;
   logic [QW-1:0] dvd_ff;
   logic [6:0]  dcnt_ff;
   logic        keep_ff, byp_ff;

   assign mode = mode_ff;
   // multiply by the fnv prime as shifts and adds
   assign hmix = hash_ff ^ {56'd0, req_data_byte};
   assign hash_in = (hmix << 40) + (hmix << 8) + (hmix << 7) + (hmix << 5) +
                    (hmix << 4) + (hmix << 1) + hmix;

   logic [COUNT_WIDTH-1:0] acnt_inc;
   assign acnt_inc = (acnt_ff < CNT_MAX) ? acnt_ff + 1'b1 : CNT_MAX;

   always_comb begin
      sts.is_last = req_last_byte;
      sts.need_div = (ael_ff >= ADAPT_PERIOD) && ({32'd0, acnt_inc} > {32'd0, thr_ff});
      sts.div_done = (dcnt_ff == 7'd0);
      sts.allow_done = prod_vld_ff;
   end

   function automatic logic [63:0] xs(input logic [63:0] v);
      logic [63:0] x;
      x = v ^ (v << 13);
      x = x ^ (x >> 7);
      x = x ^ (x << 17);
      return x;
   endfunction

   logic [63:0] rng_nx;
   logic [QW-1:0] rem_sh, rate_q;
   logic [LW-1:0] lnext, lneed;
   logic        lim_clr;
   logic [COUNT_WIDTH-1:0] lcur;
   logic [16:0] rate_use, new_eff;
   logic        use_rand, kp, bp;
   logic [63:0] hx;

   assign rng_nx = xs(rng_ff);
   assign rem_sh = {rem_ff[QW-2:0], dvd_ff[QW-1]};
   assign rate_q = (quo_ff < {{(QW-17){1'b0}}, minrt_ff}) ?
                   {{(QW-17){1'b0}}, minrt_ff} : quo_ff;
   assign lim_clr = lel_ff >= win_ff;
   assign lcur = lim_clr ? '0 : lcnt_ff;
   // count below allowance when (count + 1) * 1000 fits in the product
   assign lnext = LW'(lcur) + LW'(1);
   assign lneed = (lnext << 10) - (lnext << 4) - (lnext << 3);
   assign hx = hfin_ff ^ seed_ff;

   always_comb begin
      new_eff = eff_ff;
      if (ael_ff >= ADAPT_PERIOD) new_eff = (nval_ff != '0) ? rate_q[16:0] : base_ff;
      rate_use = (mode_ff == MODE_ADAPT) ? new_eff : base_ff;
      use_rand = 1'b0;
      kp = 1'b1;
      bp = 1'b0;
      if (mode_ff == MODE_OFF || mode_ff > MODE_HASH) kp = 1'b1;
      else if (bypass_ff[lvl_ff]) bp = 1'b1;
      else if (mode_ff == MODE_RAND || mode_ff == MODE_ADAPT) begin
         if ({{(QW-17){1'b0}}, rate_use} >= RATE_FULL) kp = 1'b1;
         else if (rate_use == '0) kp = 1'b0;
         else begin
            use_rand = 1'b1;
            kp = {{(QW-RATE_BITS){1'b0}}, rng_nx[63 -: RATE_BITS]} < {{(QW-17){1'b0}}, rate_use};
         end
      end else if (mode_ff == MODE_LIMIT) begin
         kp = (lcur == '0) || (lneed <= LW'(prod_ff));
      end else begin
         if ({{(QW-17){1'b0}}, base_ff} >= RATE_FULL) kp = 1'b1;
         else if (base_ff == '0) kp = 1'b0;
         else kp = {{(QW-RATE_BITS){1'b0}}, hx[63 -: RATE_BITS]} < {{(QW-17){1'b0}}, base_ff};
      end
   end

   function automatic logic [COUNT_WIDTH-1:0] sinc(input logic [COUNT_WIDTH-1:0] v);
      return (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
   endfunction

   function automatic logic [31:0] o32(input logic [COUNT_WIDTH-1:0] v);
      return ({{(64-COUNT_WIDTH){1'b0}}, v} > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(v);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_OFF; base_ff <= 17'h10000; bypass_ff <= '0;
         lps_ff <= 20'd1000; win_ff <= 16'd1000; thr_ff <= 32'd50000;
         minrt_ff <= 17'd655; seed_ff <= '0;
         rng_ff <= RNG_SEED; hash_ff <= FNV_BASIS; hfin_ff <= '0;
         lel_ff <= '0; ael_ff <= '0; lcnt_ff <= '0; acnt_ff <= '0;
         eff_ff <= 17'h10000; thr_flag_ff <= 1'b0;
         st0_ff <= '0; st1_ff <= '0; st2_ff <= '0; st3_ff <= '0;
         prod_vld_ff <= 1'b0; dcnt_ff <= '0; nval_ff <= '0;
         lvl_ff <= '0; prod_ff <= '0; rem_ff <= '0; quo_ff <= '0; dvd_ff <= '0;
         keep_ff <= 1'b0; byp_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_MODE:   mode_ff <= csr_data[2:0];
               REG_BASE: begin
                  base_ff <= csr_data[16:0];
                  eff_ff <= csr_data[16:0];
               end
               REG_BYPASS: bypass_ff <= csr_data[7:0];
               REG_LIMIT:  lps_ff <= csr_data[19:0];
               REG_WINDOW: win_ff <= csr_data[15:0];
               REG_THRESH: thr_ff <= csr_data[31:0];
               REG_MINRT:  minrt_ff <= csr_data[16:0];
               REG_SEED:   seed_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.take_tick) begin
            lel_ff <= (lel_ff < ELAPSED_MAX) ? lel_ff + 1'b1 : ELAPSED_MAX;
            ael_ff <= (ael_ff < ELAPSED_MAX) ? ael_ff + 1'b1 : ELAPSED_MAX;
         end
         prod_vld_ff <= 1'b0;
         if (cmd.take_byte) begin
            if (req_last_byte) begin
               hash_ff <= FNV_BASIS;
               hfin_ff <= hash_in;
               lvl_ff <= req_level;
               prod_ff <= lps_ff * win_ff;
               prod_vld_ff <= 1'b1;
               nval_ff <= cmd.div_start ? acnt_inc : '0;
            end else hash_ff <= hash_in;
         end
         if (cmd.div_start) begin
            dvd_ff <= {{(QW-49){1'b0}}, 49'(base_ff) * 49'(thr_ff)};
            rem_ff <= '0;
            quo_ff <= '0;
            dcnt_ff <= 7'(QW);
         end
         if (cmd.div_step && dcnt_ff != 7'd0) begin
            dvd_ff <= dvd_ff << 1;
            dcnt_ff <= dcnt_ff - 1'b1;
            if (rem_sh >= {{(QW-COUNT_WIDTH){1'b0}}, nval_ff}) begin
               rem_ff <= rem_sh - {{(QW-COUNT_WIDTH){1'b0}}, nval_ff};
               quo_ff <= {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[QW-2:0], 1'b0};
            end
         end
         if (cmd.decide) begin
            st0_ff <= sinc(st0_ff);
            keep_ff <= kp || bp;
            byp_ff <= bp;
            if (bp) st3_ff <= sinc(st3_ff);
            else if (kp) st1_ff <= sinc(st1_ff);
            else st2_ff <= sinc(st2_ff);
            if (use_rand) rng_ff <= rng_nx;
            if (!bp && mode_ff == MODE_LIMIT) begin
               if (lim_clr) lel_ff <= '0;
               lcnt_ff <= sinc(lcur);
            end
            if (!bp && mode_ff == MODE_ADAPT) begin
               if (ael_ff >= ADAPT_PERIOD) begin
                  acnt_ff <= '0;
                  ael_ff <= '0;
                  if (nval_ff != '0) begin
                     eff_ff <= new_eff;
                     thr_flag_ff <= 1'b1;
                  end else begin
                     eff_ff <= base_ff;
                     thr_flag_ff <= 1'b0;
                  end
               end else acnt_ff <= acnt_inc;
            end
         end
      end
   end

   always_comb begin
      rsp_keep = keep_ff;
      rsp_bypassed = byp_ff;
      rsp_throttling = thr_flag_ff;
      rsp_current_rate = eff_ff;
      rsp_total_seen = o32(st0_ff);
      rsp_kept_seen = o32(st1_ff);
      rsp_dropped_seen = o32(st2_ff);
      rsp_bypass_seen = o32(st3_ff);
   end
endmodule
`default_nettype wire

// ===== rtl/core/event_sampling_filter_top.sv =====
// ticks and non-last bytes: accepted one beat per cycle while no decision is pending
// last byte: the decision is made in ST_DECIDE, then the result beat is offered in ST_OUT
// rate limit mode adds the ST_ALLOW state, adaptive recompute adds ST_DIV (50-step divider)
// input stalls while a decision is pending or its result beat is not yet taken
// reset: synchronous active high, restores register defaults and all counters
`default_nettype none
module event_sampling_filter_top #(
   parameter int RATE_BITS = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [2:0]  req_level,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_keep,
   output logic             rsp_bypassed,
   output logic             rsp_throttling,
   output logic [16:0]      rsp_current_rate,
   output logic [31:0]      rsp_total_seen,
   output logic [31:0]      rsp_kept_seen,
   output logic [31:0]      rsp_dropped_seen,
   output logic [31:0]      rsp_bypass_seen,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   import esf_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic [2:0] mode;

   assign csr_ready = 1'b1;

   esf_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_kind, .req_stall,
      .rsp_valid, .rsp_stall, .mode, .sts, .cmd
   );

   esf_dp #(.RATE_BITS(RATE_BITS), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
      .clock, .reset, .cmd, .sts, .req_level, .req_data_byte, .req_last_byte,
      .csr_we(csr_valid), .csr_index, .csr_data, .mode,
      .rsp_keep, .rsp_bypassed, .rsp_throttling, .rsp_current_rate,
      .rsp_total_seen, .rsp_kept_seen, .rsp_dropped_seen, .rsp_bypass_seen
   );
endmodule
`default_nettype wire
